/* rtl/bounded_deque_macros.svh */
// Assertion helpers for the bounded deque.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BDQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bounded_deque: check failed");

// Delayed implication, checked out of reset.
`define BDQ_ASSERT_LAT2(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error("bounded_deque: latency check failed");

`endif

/* rtl/bdq_pkg.sv */
package bdq_pkg;

  localparam int MAX_DEPTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
  localparam int CAP_W     = 11;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W    = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef enum logic [2:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_REAR  = 3'd1,
    CMD_DEL_FRONT = 3'd2,
    CMD_DEL_REAR  = 3'd3,
    CMD_QUERY     = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] front_value;
    logic signed [WORD_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr_front;
    logic [ADDR_W-1:0] raddr_rear;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic              is_empty;
    logic              is_full;
    logic              front_byp;
    logic              rear_byp;
    logic [WORD_W-1:0] byp_value;
  } res_ctl_t;

endpackage

/* rtl/bdq_ram.sv */
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read at the write address returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/bdq_ctrl.sv */
module bdq_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                op_valid,
  input  bdq_pkg::in_t                        op,
  input  logic                                capacity_we,
  input  logic [bdq_pkg::CAP_W-1:0]           capacity_wdata,
  output bdq_pkg::mem_req_t                   mem,
  output bdq_pkg::res_ctl_t                   flags
);

  localparam int ADDR_W = bdq_pkg::ADDR_W;
  localparam int CNT_W  = bdq_pkg::CNT_W;
  localparam int CMP_W  = bdq_pkg::CMP_W;
  localparam int DEPTH  = bdq_pkg::MAX_DEPTH;

  logic [ADDR_W-1:0]         head, head_next;
  logic [ADDR_W-1:0]         rear, rear_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [bdq_pkg::CAP_W-1:0] capacity;
  logic [CMP_W-1:0]          cap_eff;
  logic                      empty_now, full_now;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    wrap_inc = (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] wrap_dec(input logic [ADDR_W-1:0] a);
    wrap_dec = (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
  endfunction

  // zero acts as one, anything past the store size as the store size
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = CMP_W'(capacity);
    end
  end

  assign empty_now = (count == '0);
  assign full_now  = (CMP_W'(count) >= cap_eff);

  // rear always points at head + count - 1 (mod depth)
  always_comb begin
    head_next       = head;
    rear_next       = rear;
    count_next      = count;
    mem.we          = 1'b0;
    mem.waddr       = head;
    mem.wdata       = op.value;
    flags.ok        = 1'b0;
    flags.front_byp = 1'b0;
    flags.rear_byp  = 1'b0;
    unique case (op.command)
      bdq_pkg::CMD_INS_FRONT: begin
        if (!full_now) begin
          head_next       = wrap_dec(head);
          count_next      = count + 1'b1;
          mem.we          = op_valid;
          mem.waddr       = head_next;
          flags.ok        = 1'b1;
          flags.front_byp = 1'b1;
          flags.rear_byp  = empty_now;
        end
      end
      bdq_pkg::CMD_INS_REAR: begin
        if (!full_now) begin
          rear_next       = wrap_inc(rear);
          count_next      = count + 1'b1;
          mem.we          = op_valid;
          mem.waddr       = rear_next;
          flags.ok        = 1'b1;
          flags.rear_byp  = 1'b1;
          flags.front_byp = empty_now;
        end
      end
      bdq_pkg::CMD_DEL_FRONT: begin
        if (!empty_now) begin
          head_next  = wrap_inc(head);
          count_next = count - 1'b1;
          flags.ok   = 1'b1;
        end
      end
      bdq_pkg::CMD_DEL_REAR: begin
        if (!empty_now) begin
          rear_next  = wrap_dec(rear);
          count_next = count - 1'b1;
          flags.ok   = 1'b1;
        end
      end
      bdq_pkg::CMD_QUERY: begin
        flags.ok = 1'b1;
      end
      default: begin
      end
    endcase
    mem.raddr_front = head_next;
    mem.raddr_rear  = rear_next;
    flags.is_empty  = (count_next == '0);
    flags.is_full   = (CMP_W'(count_next) >= cap_eff);
    flags.byp_value = op.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      rear     <= ADDR_W'(DEPTH - 1);
      count    <= '0;
      capacity <= bdq_pkg::CAP_RESET;
    end else begin
      if (op_valid) begin
        head  <= head_next;
        rear  <= rear_next;
        count <= count_next;
      end
      if (capacity_we && empty_now) begin
        capacity <= capacity_wdata;
      end
    end
  end

endmodule

/* rtl/bounded_deque.sv */
// Bounded double-ended queue of signed 32-bit words.
//
// Command channel: drive item (command, value) with start high; the word is
// taken at any rising edge where start is high and busy is low. busy is high
// only during reset and the first cycle after it, so one command can be
// issued every cycle.
// Result channel: done pulses for one cycle with result (ok, front and rear
// words, empty and full flags after the command). The receiver cannot
// stall; every command produces exactly one result, in order.
// From accept to done a command passes the input register, then the state
// update and the 1024-entry store read, whose registered read data feeds the
// result mux beside the registered flags. Throughput is one command per cycle;
// the store has one write and two read ports (front and rear) per cycle.
// Front and rear read -1 when the deque is empty.
// capacity_we/capacity_wdata write the capacity register; a write is
// dropped unless the deque is empty. Zero acts as one, values past the store
// size as the store size.
// Reset (rst, synchronous) empties the deque and sets capacity to 1024.
`include "bounded_deque_macros.svh"

module bounded_deque (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  bdq_pkg::in_t              item,
  output logic                      done,
  output bdq_pkg::out_t             result,
  input  logic                      capacity_we,
  input  logic [bdq_pkg::CAP_W-1:0] capacity_wdata
);

  localparam int WORD_W = bdq_pkg::WORD_W;

  logic              accept;
  logic              op_valid;
  bdq_pkg::in_t      op;
  bdq_pkg::mem_req_t mem;
  bdq_pkg::res_ctl_t flags;
  logic              res_valid;
  bdq_pkg::res_ctl_t res;
  logic [WORD_W-1:0] rdata_front, rdata_rear;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      op_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      busy      <= 1'b0;
      op_valid  <= accept;
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= item;
    end
    res <= flags;
  end

  bdq_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .op_valid       (op_valid),
    .op             (op),
    .capacity_we    (capacity_we),
    .capacity_wdata (capacity_wdata),
    .mem            (mem),
    .flags          (flags)
  );

  bdq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (bdq_pkg::MAX_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (mem.wdata),
    .raddr_a (mem.raddr_front),
    .raddr_b (mem.raddr_rear),
    .rdata_a (rdata_front),
    .rdata_b (rdata_rear)
  );

  // a word inserted in the same cycle is not yet visible in the read data
  assign done            = res_valid;
  assign result.ok       = res.ok;
  assign result.is_empty = res.is_empty;
  assign result.is_full  = res.is_full;
  assign result.front_value = res.is_empty  ? '1 :
                              res.front_byp ? res.byp_value : rdata_front;
  assign result.rear_value  = res.is_empty  ? '1 :
                              res.rear_byp  ? res.byp_value : rdata_rear;

  `BDQ_ASSERT_LAT2(a_latency, accept, done)
  `BDQ_ASSERT_IMPL(a_empty_not_full, done, !(result.is_empty && result.is_full))
  `BDQ_ASSERT_IMPL(a_empty_rd, done && result.is_empty, &result.front_value && &result.rear_value)

endmodule
